// ===== src/animation_frame_sequencer_unit_macros.svh =====
// Assertion macros shared by the animation frame sequencer modules.
`ifndef ANIMATION_FRAME_SEQUENCER_UNIT_MACROS_SVH
`define ANIMATION_FRAME_SEQUENCER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define AFS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define AFS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/afs_pkg.sv =====
// Shared types and constants of the animation frame sequencer.
`timescale 1ns / 1ps

package afs_pkg;

  localparam int OPCODE_W    = 3;
  localparam int DELTA_W     = 16;
  localparam int IDX_W       = 13;
  localparam int SCALE_W     = 16;
  localparam int PROD_W      = 32;
  localparam int SCALED_W    = 24;
  localparam int SUM_W       = 25;
  localparam int STEPS_W     = 8;
  localparam int ELAPSED_W   = 32;
  localparam int FRAME_OUT_W = 12;
  localparam int COUNT_IN_W  = 13;
  localparam int DUR_IN_W    = 24;
  localparam int COUNT_LIMIT = 8191;
  localparam int CFG_AW      = 3;
  localparam int CFG_DW      = 24;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 56;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd256;

  localparam logic [OPCODE_W-1:0] OP_TICK  = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_STOP  = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_SET   = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_PLAY  = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_PAUSE = 3'd4;

  localparam logic [CFG_AW-1:0] REG_FRAME_COUNT    = 3'd0;
  localparam logic [CFG_AW-1:0] REG_FRAME_DURATION = 3'd1;
  localparam logic [CFG_AW-1:0] REG_PLAY_BACKWARD  = 3'd2;
  localparam logic [CFG_AW-1:0] REG_PING_PONG      = 3'd3;
  localparam logic [CFG_AW-1:0] REG_LOOPING        = 3'd4;
  localparam logic [CFG_AW-1:0] REG_DELTA_SCALE    = 3'd5;

  typedef struct packed {
    logic load_in;
    logic mul;
    logic exec_op;
    logic acc;
    logic div_take;
    logic mod_start;
    logic mod_take;
    logic step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic adv;
    logic div_done;
    logic n_zero;
    logic need_mod;
    logic step_stop;
  } sts_t;

endpackage

// ===== src/afs_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module afs_div #(
  parameter int DIVIDEND_W = 25,
  parameter int DIVISOR_W  = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient,
  output logic [DIVISOR_W-1:0]  remainder
);

  localparam int CTW = $clog2(DIVIDEND_W + 1);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [CTW-1:0]        cnt_r, cnt_nxt;
  logic [DIVIDEND_W-1:0] q_r, q_nxt;
  logic [DIVISOR_W-1:0]  rem_r, rem_nxt;
  logic [DIVISOR_W-1:0]  dvs_r, dvs_nxt;
  logic [DIVISOR_W:0]    shifted;
  logic [DIVISOR_W:0]    diff;

  assign shifted = {rem_r, q_r[DIVIDEND_W-1]};
  assign diff    = shifted - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CTW'(DIVIDEND_W);
      q_nxt    = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      if (shifted >= {1'b0, dvs_r}) begin
        rem_nxt = diff[DIVISOR_W-1:0];
        q_nxt   = {q_r[DIVIDEND_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[DIVISOR_W-1:0];
        q_nxt   = {q_r[DIVIDEND_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CTW'(1);
      if (cnt_r == CTW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done      = done_r;
  assign quotient  = q_r;
  assign remainder = rem_r;

endmodule

// ===== src/afs_ctrl.sv =====
// Controller state machine of the animation frame sequencer.
`timescale 1ns / 1ps
`include "animation_frame_sequencer_unit_macros.svh"

module afs_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  input  afs_pkg::sts_t sts,
  output afs_pkg::cmd_t cmd
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_EXEC = 8'b0000_0010,
    S_ACC  = 8'b0000_0100,
    S_DIV  = 8'b0000_1000,
    S_STEP = 8'b0001_0000,
    S_MOD  = 8'b0010_0000,
    S_DONE = 8'b0100_0000,
    S_SPARE = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.adv) begin
          cmd.mul   = 1'b1;
          state_nxt = S_ACC;
        end else begin
          cmd.exec_op = 1'b1;
          state_nxt   = S_DONE;
        end
      end
      S_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.div_take = 1'b1;
          state_nxt    = S_STEP;
        end
      end
      S_STEP: begin
        if (sts.n_zero) begin
          state_nxt = S_DONE;
        end else if (sts.need_mod) begin
          cmd.mod_start = 1'b1;
          state_nxt     = S_MOD;
        end else begin
          cmd.step = 1'b1;
          if (sts.step_stop) begin
            state_nxt = S_DONE;
          end
        end
      end
      S_MOD: begin
        if (sts.div_done) begin
          cmd.mod_take = 1'b1;
          state_nxt    = S_STEP;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `AFS_ASSERT_NXT(a_accept_goes_exec, in_tvalid && in_tready, state_r == S_EXEC, "accepted item did not enter execution")
  `AFS_ASSERT_IMP(a_div_done_waited, sts.div_done, (state_r == S_DIV) || (state_r == S_MOD), "divider finished while nobody waited for it")

endmodule

// ===== src/afs_dp.sv =====
// Datapath of the animation frame sequencer: registers, scaling, stepping.
`timescale 1ns / 1ps
`include "animation_frame_sequencer_unit_macros.svh"

module afs_dp #(
  parameter int MAX_FRAMES = 4096,
  parameter int TIME_WIDTH = 24
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [afs_pkg::CFG_AW-1:0]          cfg_addr,
  input  logic [afs_pkg::CFG_DW-1:0]          cfg_wdata,
  input  logic [afs_pkg::OPCODE_W-1:0]        in_opcode,
  input  logic [afs_pkg::DELTA_W-1:0]         in_delta_time,
  input  logic signed [afs_pkg::IDX_W-1:0]    in_frame_index,
  input  logic                                in_freeze,
  input  afs_pkg::cmd_t                       cmd,
  output afs_pkg::sts_t                       sts,
  output logic [afs_pkg::FRAME_OUT_W-1:0]     out_current_frame,
  output logic                                out_frame_changed,
  output logic [afs_pkg::STEPS_W-1:0]         out_frames_stepped,
  output logic                                out_playing,
  output logic                                out_at_last_frame,
  output logic [afs_pkg::ELAPSED_W-1:0]       out_total_elapsed
);

  localparam int CNT_MAX = (MAX_FRAMES < afs_pkg::COUNT_LIMIT) ? MAX_FRAMES
                                                               : afs_pkg::COUNT_LIMIT;
  localparam int FIW = $clog2(CNT_MAX);
  localparam int CNW = $clog2(CNT_MAX + 1);
  localparam int XW  = CNW + 1;
  localparam int DW  = (TIME_WIDTH < afs_pkg::DUR_IN_W) ? TIME_WIDTH : afs_pkg::DUR_IN_W;
  localparam int DVW = (DW > XW) ? DW : XW;
  localparam int SW  = afs_pkg::SUM_W;

  // Configuration registers.
  logic [CNW-1:0]                   count_r, count_nxt;
  logic [DW-1:0]                    dur_r, dur_nxt;
  logic                             pb_r, pb_nxt;
  logic                             pp_r, pp_nxt;
  logic                             loop_r, loop_nxt;
  logic [afs_pkg::SCALE_W-1:0]      scale_r, scale_nxt;

  // Playback state.
  logic [FIW-1:0]                   frame_r, frame_nxt;
  logic                             dir_r, dir_nxt;
  logic                             first_r, first_nxt;
  logic [DW-1:0]                    acc_r, acc_nxt;
  logic [afs_pkg::ELAPSED_W-1:0]    elapsed_r, elapsed_nxt;
  logic                             play_r, play_nxt;

  // Current item and work registers.
  logic [afs_pkg::OPCODE_W-1:0]     op_r, op_nxt;
  logic [afs_pkg::DELTA_W-1:0]      delta_r, delta_nxt;
  logic signed [afs_pkg::IDX_W-1:0] idx_r, idx_nxt;
  logic                             freeze_r, freeze_nxt;
  logic [afs_pkg::PROD_W-1:0]       prod_r, prod_nxt;
  logic [SW-1:0]                    n_r, n_nxt;
  logic [afs_pkg::STEPS_W-1:0]      steps_r, steps_nxt;
  logic                             changed_r, changed_nxt;

  // Result registers.
  logic [afs_pkg::FRAME_OUT_W-1:0]  ofr_r, ofr_nxt;
  logic                             och_r, och_nxt;
  logic [afs_pkg::STEPS_W-1:0]      ost_r, ost_nxt;
  logic                             opl_r, opl_nxt;
  logic                             ola_r, ola_nxt;
  logic [afs_pkg::ELAPSED_W-1:0]    oel_r, oel_nxt;

  logic [XW-1:0]                    count_x, frame_x, last_x, period;
  logic [FIW-1:0]                   last_f;
  logic                             at_end, on_cycle;
  logic                             fwd, top, bot;
  logic                             st_pause, st_dir, st_move, st_up;
  logic [FIW-1:0]                   st_frame;
  logic [afs_pkg::SCALED_W-1:0]     scaled;
  logic [SW-1:0]                    sum;
  logic [afs_pkg::ELAPSED_W:0]      esum;
  logic [31:0]                      idx32, frame32;
  logic                             idx_in_range;
  logic [COUNT_IN_W_L-1:0]          cfg_count;

  localparam int COUNT_IN_W_L = afs_pkg::COUNT_IN_W;

  logic                             div_start, div_done;
  logic [SW-1:0]                    div_dividend, div_q;
  logic [DVW-1:0]                   div_divisor, div_rem;

  assign count_x = XW'(count_r);
  assign frame_x = XW'(frame_r);
  assign last_x  = count_x - XW'(1);
  assign last_f  = last_x[FIW-1:0];
  assign period  = pp_r ? (last_x << 1) : count_x;

  assign at_end = pb_r ? (frame_r == '0) : ((count_r != '0) && (frame_x == last_x));

  always_comb begin
    on_cycle = 1'b1;
    if (frame_x >= count_x) begin
      on_cycle = 1'b0;
    end else if (pp_r) begin
      if ((frame_r == '0) && !dir_r) begin
        on_cycle = 1'b0;
      end else if ((frame_x == last_x) && dir_r) begin
        on_cycle = 1'b0;
      end
    end
  end

  // One frame step in the current direction, with the end-of-range policy.
  always_comb begin
    fwd      = !dir_r;
    top      = fwd && ((frame_x + XW'(1)) >= count_x);
    bot      = !fwd && (frame_r == '0);
    st_pause = 1'b0;
    st_dir   = dir_r;
    st_move  = 1'b1;
    st_up    = fwd;
    st_frame = frame_r;
    if (top || bot) begin
      if (!pp_r) begin
        st_move = 1'b0;
        if (!loop_r) begin
          st_pause = 1'b1;
        end else begin
          st_frame = top ? '0 : last_f;
        end
      end else if (!loop_r && ((!pb_r && bot) || (pb_r && top))) begin
        st_pause = 1'b1;
        st_dir   = pb_r;
        st_move  = 1'b0;
      end else begin
        st_dir = !dir_r;
        st_up  = !fwd;
      end
    end
    if (st_move) begin
      st_frame = st_up ? (frame_r + FIW'(1)) : (frame_r - FIW'(1));
    end
  end

  assign scaled = prod_r[afs_pkg::PROD_W-1:8];
  assign sum    = first_r ? '0 : (SW'(acc_r) + SW'(scaled));
  assign esum   = (afs_pkg::ELAPSED_W + 1)'(elapsed_r) + (afs_pkg::ELAPSED_W + 1)'(scaled);

  assign idx32        = 32'(idx_r[afs_pkg::FRAME_OUT_W-1:0]);
  assign frame32      = 32'(frame_r);
  assign idx_in_range = !idx_r[afs_pkg::IDX_W-1] && (idx32 < 32'(count_r));
  assign cfg_count    = cfg_wdata[COUNT_IN_W_L-1:0];

  assign sts.adv       = (op_r == afs_pkg::OP_TICK) && !freeze_r && play_r &&
                         (count_x >= XW'(2)) && (dur_r != '0);
  assign sts.div_done  = div_done;
  assign sts.n_zero    = (n_r == '0);
  assign sts.need_mod  = loop_r && on_cycle && (n_r > SW'(period));
  assign sts.step_stop = st_pause;

  assign div_start    = cmd.acc || cmd.mod_start;
  assign div_dividend = cmd.acc ? sum : n_r;
  assign div_divisor  = cmd.acc ? DVW'(dur_r) : DVW'(period);

  afs_div #(
    .DIVIDEND_W (SW),
    .DIVISOR_W  (DVW)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_rem)
  );

  always_comb begin
    count_nxt   = count_r;
    dur_nxt     = dur_r;
    pb_nxt      = pb_r;
    pp_nxt      = pp_r;
    loop_nxt    = loop_r;
    scale_nxt   = scale_r;
    frame_nxt   = frame_r;
    dir_nxt     = dir_r;
    first_nxt   = first_r;
    acc_nxt     = acc_r;
    elapsed_nxt = elapsed_r;
    play_nxt    = play_r;
    op_nxt      = op_r;
    delta_nxt   = delta_r;
    idx_nxt     = idx_r;
    freeze_nxt  = freeze_r;
    prod_nxt    = prod_r;
    n_nxt       = n_r;
    steps_nxt   = steps_r;
    changed_nxt = changed_r;
    ofr_nxt     = ofr_r;
    och_nxt     = och_r;
    ost_nxt     = ost_r;
    opl_nxt     = opl_r;
    ola_nxt     = ola_r;
    oel_nxt     = oel_r;

    if (cmd.load_in) begin
      op_nxt      = in_opcode;
      delta_nxt   = in_delta_time;
      idx_nxt     = in_frame_index;
      freeze_nxt  = in_freeze;
      steps_nxt   = '0;
      changed_nxt = 1'b0;
    end

    if (cmd.mul) begin
      prod_nxt = afs_pkg::PROD_W'(delta_r) * afs_pkg::PROD_W'(scale_r);
    end

    if (cmd.exec_op) begin
      case (op_r)
        afs_pkg::OP_STOP: begin
          elapsed_nxt = '0;
          first_nxt   = 1'b1;
          play_nxt    = 1'b0;
          if (pb_r) begin
            dir_nxt = 1'b1;
            if (count_r != '0) begin
              frame_nxt   = last_f;
              changed_nxt = 1'b1;
            end
          end else begin
            dir_nxt     = 1'b0;
            frame_nxt   = '0;
            changed_nxt = 1'b1;
          end
        end
        afs_pkg::OP_SET: begin
          if (idx_in_range) begin
            frame_nxt   = idx32[FIW-1:0];
            first_nxt   = 1'b1;
            changed_nxt = 1'b1;
          end else if ((&idx_r) && (count_r != '0)) begin
            frame_nxt   = pb_r ? '0 : last_f;
            first_nxt   = 1'b1;
            changed_nxt = 1'b1;
          end
        end
        afs_pkg::OP_PLAY: begin
          play_nxt = 1'b1;
        end
        afs_pkg::OP_PAUSE: begin
          play_nxt = 1'b0;
        end
        default: begin
        end
      endcase
    end

    if (cmd.acc) begin
      first_nxt = 1'b0;
      if (first_r) begin
        elapsed_nxt = '0;
      end else begin
        elapsed_nxt = esum[afs_pkg::ELAPSED_W] ? '1 : esum[afs_pkg::ELAPSED_W-1:0];
      end
    end

    if (cmd.div_take) begin
      n_nxt   = div_q;
      acc_nxt = div_rem[DW-1:0];
    end

    if (cmd.mod_take) begin
      n_nxt = SW'(div_rem);
    end

    if (cmd.step) begin
      n_nxt     = n_r - SW'(1);
      frame_nxt = st_frame;
      dir_nxt   = st_dir;
      if (st_pause) begin
        play_nxt  = 1'b0;
        first_nxt = 1'b1;
      end else if (steps_r != '1) begin
        steps_nxt = steps_r + afs_pkg::STEPS_W'(1);
      end
    end

    if (cmd.emit) begin
      ofr_nxt = frame32[afs_pkg::FRAME_OUT_W-1:0];
      och_nxt = changed_r || (steps_r != '0);
      ost_nxt = steps_r;
      opl_nxt = play_r;
      ola_nxt = at_end;
      oel_nxt = elapsed_r;
    end

    if (cfg_we) begin
      unique case (cfg_addr)
        afs_pkg::REG_FRAME_COUNT: begin
          count_nxt = (cfg_count > COUNT_IN_W_L'(CNT_MAX)) ? CNW'(CNT_MAX) : CNW'(cfg_count);
        end
        afs_pkg::REG_FRAME_DURATION: begin
          dur_nxt = cfg_wdata[DW-1:0];
        end
        afs_pkg::REG_PLAY_BACKWARD: begin
          pb_nxt  = cfg_wdata[0];
          dir_nxt = cfg_wdata[0];
        end
        afs_pkg::REG_PING_PONG: begin
          if (pp_r && !cfg_wdata[0]) begin
            dir_nxt = pb_r;
          end
          pp_nxt = cfg_wdata[0];
        end
        afs_pkg::REG_LOOPING: begin
          loop_nxt = cfg_wdata[0];
        end
        afs_pkg::REG_DELTA_SCALE: begin
          scale_nxt = cfg_wdata[afs_pkg::SCALE_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      dur_r     <= '0;
      pb_r      <= 1'b0;
      pp_r      <= 1'b0;
      loop_r    <= 1'b0;
      scale_r   <= afs_pkg::SCALE_RESET;
      frame_r   <= '0;
      dir_r     <= 1'b0;
      first_r   <= 1'b1;
      acc_r     <= '0;
      elapsed_r <= '0;
      play_r    <= 1'b0;
    end else begin
      count_r   <= count_nxt;
      dur_r     <= dur_nxt;
      pb_r      <= pb_nxt;
      pp_r      <= pp_nxt;
      loop_r    <= loop_nxt;
      scale_r   <= scale_nxt;
      frame_r   <= frame_nxt;
      dir_r     <= dir_nxt;
      first_r   <= first_nxt;
      acc_r     <= acc_nxt;
      elapsed_r <= elapsed_nxt;
      play_r    <= play_nxt;
    end
    op_r      <= op_nxt;
    delta_r   <= delta_nxt;
    idx_r     <= idx_nxt;
    freeze_r  <= freeze_nxt;
    prod_r    <= prod_nxt;
    n_r       <= n_nxt;
    steps_r   <= steps_nxt;
    changed_r <= changed_nxt;
    ofr_r     <= ofr_nxt;
    och_r     <= och_nxt;
    ost_r     <= ost_nxt;
    opl_r     <= opl_nxt;
    ola_r     <= ola_nxt;
    oel_r     <= oel_nxt;
  end

  assign out_current_frame  = ofr_r;
  assign out_frame_changed  = och_r;
  assign out_frames_stepped = ost_r;
  assign out_playing        = opl_r;
  assign out_at_last_frame  = ola_r;
  assign out_total_elapsed  = oel_r;

  `AFS_ASSERT_NXT(a_acc_below_duration, cmd.div_take, DVW'(acc_r) < DVW'(dur_r), "frame time remainder not below the frame duration")
  `AFS_ASSERT_NXT(a_steps_below_period, cmd.mod_take, n_r < SW'(period), "reduced step count not below the loop period")

endmodule

// ===== src/animation_frame_sequencer_unit.sv =====
// A stop, set, play, pause or non-advancing tick is loaded, executed and then emitted into
// the output register once it is free. An advancing tick is scaled, accumulated and split
// into frames by the bit-serial divider; its frames are then stepped one step per cycle,
// paused only by a loop-period reduction of the step count, which costs one more divider pass.
// One item is worked on at a time; the next is taken while a result waits in the output register.
// Reset (rst_n low, synchronous) restores register defaults and clears playback state.
`timescale 1ns / 1ps

module animation_frame_sequencer_unit #(
  parameter int MAX_FRAMES = 4096,
  parameter int TIME_WIDTH = 24
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [afs_pkg::CFG_AW-1:0]         cfg_addr,
  input  logic [afs_pkg::CFG_DW-1:0]         cfg_wdata,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // delta_time[15:0], frame_index[28:16], freeze[29], zero fill
  input  logic [afs_pkg::IN_TDATA_W-1:0]     in_tdata,
  // opcode[2:0]
  input  logic [afs_pkg::OPCODE_W-1:0]       in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // current_frame[11:0], frame_changed[12], frames_stepped[20:13], playing[21],
  // at_last_frame[22], total_elapsed[54:23], zero fill
  output logic [afs_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  afs_pkg::cmd_t                    cmd;
  afs_pkg::sts_t                    sts;
  logic [afs_pkg::FRAME_OUT_W-1:0]  cur_frame;
  logic                             frame_changed;
  logic [afs_pkg::STEPS_W-1:0]      frames_stepped;
  logic                             playing;
  logic                             at_last;
  logic [afs_pkg::ELAPSED_W-1:0]    total_elapsed;

  afs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  afs_dp #(
    .MAX_FRAMES (MAX_FRAMES),
    .TIME_WIDTH (TIME_WIDTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_addr           (cfg_addr),
    .cfg_wdata          (cfg_wdata),
    .in_opcode          (in_tuser),
    .in_delta_time      (in_tdata[15:0]),
    .in_frame_index     (in_tdata[28:16]),
    .in_freeze          (in_tdata[29]),
    .cmd                (cmd),
    .sts                (sts),
    .out_current_frame  (cur_frame),
    .out_frame_changed  (frame_changed),
    .out_frames_stepped (frames_stepped),
    .out_playing        (playing),
    .out_at_last_frame  (at_last),
    .out_total_elapsed  (total_elapsed)
  );

  assign out_tdata = {1'b0, total_elapsed, at_last, playing, frames_stepped,
                      frame_changed, cur_frame};

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the animation frame sequencer: directed table, random runs, scoreboard.
`timescale 1ns / 1ps

module testbench;
  import afs_pkg::*;

  localparam int MAX_FRAMES = 4096;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int HOLD_CYCLES = 400;
  localparam logic DIR_FWD = 1'b0;
  localparam logic DIR_BWD = 1'b1;

  typedef struct packed {
    logic [31:0] elapsed;
    logic        at_last;
    logic        playing;
    logic [7:0]  steps;
    logic        changed;
    logic [11:0] frame;
  } frame_status_t;

  typedef struct packed {
    logic          is_cfg;
    logic [2:0]    reg_idx;
    logic [23:0]   wdata;
    logic [2:0]    op;
    logic [15:0]   delta;
    logic [12:0]   fidx;
    logic          frz;
    logic          typed;
    frame_status_t res;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_AW-1:0] cfg_addr;
  logic [CFG_DW-1:0] cfg_wdata;
  logic in_tvalid;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata;
  logic [OPCODE_W-1:0] in_tuser;
  logic out_tvalid;
  logic out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // Predicted sequencer state and register copies.
  logic [12:0] pc_count;
  logic [23:0] pc_dur;
  logic        pc_back;
  logic        pc_pp;
  logic        pc_loop;
  logic [15:0] pc_scale;
  logic [11:0] pc_frame;
  logic        pc_dir;
  logic        pc_first;
  logic [25:0] pc_acc;
  logic [31:0] pc_elapsed;
  logic        pc_play;

  frame_status_t frame_status_q[$];
  stim_row_t     plan_q[$];
  frame_status_t typed_status;
  frame_status_t mon_want;
  frame_status_t mon_got;
  logic          typed_pending;
  bit            tx_calm;
  bit            rx_calm;
  int            rx_hold;
  int            error_count;

  animation_frame_sequencer_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void seq_reset();
    pc_count = '0;
    pc_dur = '0;
    pc_back = 1'b0;
    pc_pp = 1'b0;
    pc_loop = 1'b0;
    pc_scale = SCALE_RESET;
    pc_frame = '0;
    pc_dir = DIR_FWD;
    pc_first = 1'b1;
    pc_acc = '0;
    pc_elapsed = '0;
    pc_play = 1'b0;
  endfunction

  function automatic void seq_write_reg(logic [2:0] r, logic [23:0] v);
    case (r)
      REG_FRAME_COUNT:
        pc_count = (v[12:0] > 13'(MAX_FRAMES)) ? 13'(MAX_FRAMES) : v[12:0];
      REG_FRAME_DURATION: pc_dur = v;
      REG_PLAY_BACKWARD: begin
        pc_back = v[0];
        pc_dir = v[0];
      end
      REG_PING_PONG: begin
        if (pc_pp && !v[0]) pc_dir = pc_back;
        pc_pp = v[0];
      end
      REG_LOOPING: pc_loop = v[0];
      REG_DELTA_SCALE: pc_scale = v[15:0];
      default: ;
    endcase
  endfunction

  function automatic bit seq_at_end();
    if (!pc_back) return pc_count != 0 && int'(pc_frame) == int'(pc_count) - 1;
    return pc_frame == 0;
  endfunction

  // True when the frame lies on the regular loop path, so whole periods can be skipped.
  function automatic bit seq_on_cycle();
    int cnt;
    int fr;
    cnt = pc_count;
    fr = pc_frame;
    if (fr >= cnt) return 1'b0;
    if (!pc_pp) return 1'b1;
    if (fr == 0 && pc_dir == DIR_FWD) return 1'b0;
    if (fr == cnt - 1 && pc_dir == DIR_BWD) return 1'b0;
    return 1'b1;
  endfunction

  function automatic bit seq_step_frame();
    int cnt;
    int fr;
    bit fwd;
    bit top;
    bit bot;
    cnt = pc_count;
    fr = pc_frame;
    fwd = (pc_dir == DIR_FWD);
    top = fwd && (fr + 1 >= cnt);
    bot = !fwd && (fr == 0);
    if (top || bot) begin
      if (!pc_pp) begin
        if (!pc_loop) begin
          pc_play = 1'b0;
          pc_first = 1'b1;
          return 1'b0;
        end
        pc_frame = top ? 12'd0 : 12'(cnt - 1);
        return 1'b1;
      end
      if (!pc_loop && ((!pc_back && bot) || (pc_back && top))) begin
        pc_play = 1'b0;
        pc_first = 1'b1;
        pc_dir = pc_back;
        return 1'b0;
      end
      pc_dir = ~pc_dir;
      fwd = !fwd;
    end
    if (fwd) pc_frame = pc_frame + 12'd1;
    else pc_frame = pc_frame - 12'd1;
    return 1'b1;
  endfunction

  function automatic logic [7:0] seq_advance(logic [15:0] delta);
    longint unsigned scaled;
    longint unsigned sum;
    longint unsigned acc;
    longint unsigned n;
    longint unsigned period;
    int cnt;
    int steps;
    cnt = pc_count;
    steps = 0;
    if (!pc_play || cnt < 2 || pc_dur == 0) return 8'd0;
    scaled = (64'(delta) * 64'(pc_scale)) >> 8;
    if (pc_first) begin
      acc = 0;
      pc_elapsed = '0;
      pc_first = 1'b0;
    end else begin
      sum = 64'(pc_elapsed) + scaled;
      pc_elapsed = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(sum);
      acc = 64'(pc_acc) + scaled;
    end
    n = acc / 64'(pc_dur);
    pc_acc = 26'(acc % 64'(pc_dur));
    while (n > 0) begin
      if (pc_loop && seq_on_cycle()) begin
        period = pc_pp ? 64'(2 * (cnt - 1)) : 64'(cnt);
        if (n > period) n = n % period;
        if (n == 0) break;
      end
      n--;
      if (!seq_step_frame()) break;
      if (steps < 255) steps++;
    end
    return 8'(steps);
  endfunction

  function automatic frame_status_t seq_apply_item(logic [2:0] op, logic [15:0] delta,
                                                   logic [12:0] fidx, logic frz);
    frame_status_t r;
    int idx;
    bit changed;
    logic [7:0] steps;
    changed = 1'b0;
    steps = '0;
    idx = int'($signed(fidx));
    case (op)
      OP_TICK: begin
        if (!frz) begin
          steps = seq_advance(delta);
          changed = (steps != 0);
        end
      end
      OP_STOP: begin
        pc_elapsed = '0;
        if (pc_back) begin
          if (pc_count > 0) begin
            pc_frame = 12'(int'(pc_count) - 1);
            changed = 1'b1;
          end
          pc_dir = DIR_BWD;
        end else begin
          pc_frame = '0;
          changed = 1'b1;
          pc_dir = DIR_FWD;
        end
        pc_first = 1'b1;
        pc_play = 1'b0;
      end
      OP_SET: begin
        if (idx >= 0 && idx < int'(pc_count)) begin
          pc_frame = 12'(idx);
          changed = 1'b1;
        end else if (idx == -1 && pc_count > 0) begin
          pc_frame = pc_back ? 12'd0 : 12'(int'(pc_count) - 1);
          changed = 1'b1;
        end
        if (changed) pc_first = 1'b1;
      end
      OP_PLAY: pc_play = 1'b1;
      OP_PAUSE: pc_play = 1'b0;
      default: ;
    endcase
    r.frame = pc_frame;
    r.changed = changed;
    r.steps = steps;
    r.playing = pc_play;
    r.at_last = seq_at_end();
    r.elapsed = pc_elapsed;
    return r;
  endfunction

  function automatic void add_cfg(logic [2:0] r, int v);
    stim_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.reg_idx = r;
    row.wdata = 24'(v);
    plan_q.push_back(row);
  endfunction

  function automatic void add_item(logic [2:0] op, int delta, int idx, logic frz);
    stim_row_t row;
    row = '0;
    row.op = op;
    row.delta = 16'(delta);
    row.fidx = 13'(idx);
    row.frz = frz;
    plan_q.push_back(row);
  endfunction

  function automatic void add_checked(logic [2:0] op, int delta, int idx, int frame,
                                      logic changed, logic playing, logic last);
    stim_row_t row;
    row = '0;
    row.op = op;
    row.delta = 16'(delta);
    row.fidx = 13'(idx);
    row.typed = 1'b1;
    row.res.frame = 12'(frame);
    row.res.changed = changed;
    row.res.playing = playing;
    row.res.at_last = last;
    plan_q.push_back(row);
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("ERROR at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  task automatic wait_drain();
    in_tvalid = 1'b0;
    cfg_we = 1'b0;
    while (frame_status_q.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] r, logic [23:0] v);
    in_tvalid = 1'b0;
    cfg_we = 1'b1;
    cfg_addr = r;
    cfg_wdata = v;
    seq_write_reg(r, v);
    @(negedge clk);
  endtask

  task automatic send_item(logic [2:0] op, logic [15:0] delta, logic [12:0] fidx, logic frz,
                           logic typed, frame_status_t want);
    int gap;
    cfg_we = 1'b0;
    gap = tx_calm ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tuser = op;
    in_tdata = {2'b00, frz, fidx, delta};
    typed_pending = typed;
    typed_status = want;
    in_tvalid = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic random_setup(bit sat_run);
    logic [23:0] val [6];
    int order [6];
    int i;
    int j;
    int t;
    case ($urandom_range(0, 15))
      0: val[REG_FRAME_COUNT] = 0;
      1: val[REG_FRAME_COUNT] = 1;
      2: val[REG_FRAME_COUNT] = $urandom_range(200, 300);
      3: val[REG_FRAME_COUNT] = $urandom_range(MAX_FRAMES, COUNT_LIMIT);
      default: val[REG_FRAME_COUNT] = $urandom_range(2, 12);
    endcase
    case ($urandom_range(0, 9))
      0: val[REG_FRAME_DURATION] = 0;
      1: val[REG_FRAME_DURATION] = 1;
      2: val[REG_FRAME_DURATION] = 24'hFFFFFF;
      default: val[REG_FRAME_DURATION] = $urandom_range(20, 3000);
    endcase
    if (val[REG_FRAME_COUNT] >= MAX_FRAMES)
      val[REG_FRAME_DURATION] = $urandom_range(1 << 20, 24'hFFFFFF);
    case ($urandom_range(0, 9))
      0: val[REG_DELTA_SCALE] = 0;
      1: val[REG_DELTA_SCALE] = 16'hFFFF;
      2: val[REG_DELTA_SCALE] = $urandom_range(1, 16'hFFFF);
      default: val[REG_DELTA_SCALE] = $urandom_range(128, 512);
    endcase
    val[REG_PLAY_BACKWARD] = $urandom_range(0, 1);
    val[REG_PING_PONG] = $urandom_range(0, 1);
    val[REG_LOOPING] = $urandom_range(0, 1);
    if (sat_run) begin
      val[REG_FRAME_COUNT] = $urandom_range(2, 12);
      val[REG_FRAME_DURATION] = 24'hFFFFFF;
      val[REG_DELTA_SCALE] = 16'hFFFF;
      val[REG_LOOPING] = 1;
    end
    for (i = 0; i < 6; i++) order[i] = i;
    for (i = 5; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    for (i = 0; i < 6; i++) write_reg(3'(order[i]), val[order[i]]);
  endtask

  task automatic random_item(bit sat_run, output logic [2:0] op, output logic [15:0] delta,
                             output logic [12:0] fidx, output logic frz);
    int r;
    r = $urandom_range(0, 99);
    delta = 16'($urandom);
    fidx = 13'($urandom);
    frz = ($urandom_range(0, 9) == 0);
    if (sat_run) begin
      if (r < 4) op = OP_PLAY;
      else if (r < 5) op = OP_PAUSE;
      else if (r < 6) op = 3'($urandom_range(OP_PAUSE + 1, 2**OPCODE_W - 1));
      else op = OP_TICK;
      if (op == OP_TICK) begin
        delta = $urandom_range(62000, 65535);
        frz = ($urandom_range(0, 29) == 0);
      end
    end else begin
      if (r < 55) op = OP_TICK;
      else if (r < 67) op = OP_PLAY;
      else if (r < 74) op = OP_STOP;
      else if (r < 84) op = OP_SET;
      else if (r < 91) op = OP_PAUSE;
      else if (r < 95) op = 3'($urandom_range(OP_PAUSE + 1, 2**OPCODE_W - 1));
      else op = OP_TICK;
      if (op == OP_TICK) begin
        case ($urandom_range(0, 9))
          0: delta = '0;
          1: delta = '1;
          2, 3: delta = 16'($urandom);
          default: delta = $urandom_range(0, 4000);
        endcase
      end
      if (op == OP_SET) begin
        r = $urandom_range(0, 9);
        if (r < 5 && pc_count > 0) fidx = 13'($urandom_range(0, int'(pc_count) - 1));
        else if (r < 7) fidx = '1;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        mon_want = seq_apply_item(in_tuser, in_tdata[15:0], in_tdata[28:16], in_tdata[29]);
        if (typed_pending) mon_want = typed_status;
        frame_status_q.push_back(mon_want);
      end
      if (out_tvalid && out_tready) begin
        mon_got = out_tdata[$bits(frame_status_t)-1:0];
        if (frame_status_q.size() == 0) begin
          report_mismatch("result without pending item, frame", mon_got.frame, 0);
        end else begin
          mon_want = frame_status_q.pop_front();
          if (mon_got.frame != mon_want.frame)
            report_mismatch("current_frame", mon_got.frame, mon_want.frame);
          if (mon_got.changed != mon_want.changed)
            report_mismatch("frame_changed", mon_got.changed, mon_want.changed);
          if (mon_got.steps != mon_want.steps)
            report_mismatch("frames_stepped", mon_got.steps, mon_want.steps);
          if (mon_got.playing != mon_want.playing)
            report_mismatch("playing", mon_got.playing, mon_want.playing);
          if (mon_got.at_last != mon_want.at_last)
            report_mismatch("at_last_frame", mon_got.at_last, mon_want.at_last);
          if (mon_got.elapsed != mon_want.elapsed)
            report_mismatch("total_elapsed", mon_got.elapsed, mon_want.elapsed);
        end
      end
    end
  end

  initial begin : result_sink
    int gap;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (rx_hold > 0) begin
        out_tready = 1'b0;
        while (rx_hold > 0) begin
          @(negedge clk);
          rx_hold--;
        end
      end
      gap = rx_calm ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
        out_tready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready = 1'b1;
      @(posedge clk);
      while (!out_tvalid && rx_hold == 0) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin : watchdog
    int n;
    for (n = 0; n < CYCLE_LIMIT; n++) @(posedge clk);
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    bit prev_cfg;
    bit sat;
    int phase;
    int k;
    int n_items;
    logic [2:0] op;
    logic [15:0] delta;
    logic [12:0] fidx;
    logic frz;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = OP_TICK;
    typed_pending = 1'b0;
    typed_status = '0;
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    rx_hold = 0;
    error_count = 0;
    seq_reset();

    add_checked(OP_PLAY, 0, 0, 0, 1'b0, 1'b1, 1'b0);
    add_checked(OP_TICK, 16'hFFFF, 0, 0, 1'b0, 1'b1, 1'b0);
    add_checked(OP_SET, 0, -1, 0, 1'b0, 1'b1, 1'b0);
    add_checked(OP_STOP, 0, 0, 0, 1'b1, 1'b0, 1'b0);
    add_checked(3'(2**OPCODE_W - 1), 0, 0, 0, 1'b0, 1'b0, 1'b0);
    add_cfg(REG_FRAME_COUNT, 8);
    add_cfg(REG_FRAME_DURATION, 100);
    add_cfg(REG_LOOPING, 1);
    add_checked(OP_SET, 0, 7, 7, 1'b1, 1'b0, 1'b1);
    add_checked(OP_SET, 0, 8, 7, 1'b0, 1'b0, 1'b1);
    add_checked(OP_SET, 0, -2, 7, 1'b0, 1'b0, 1'b1);
    add_checked(OP_PLAY, 0, 0, 7, 1'b0, 1'b1, 1'b1);
    add_checked(OP_TICK, 250, 0, 7, 1'b0, 1'b1, 1'b1);
    add_item(OP_TICK, 250, 0, 1'b0);
    add_item(OP_TICK, 16'hFFFF, 0, 1'b1);
    add_item(OP_PAUSE, 0, 0, 1'b0);
    add_cfg(REG_FRAME_COUNT, COUNT_LIMIT);
    add_cfg(REG_FRAME_DURATION, 1);
    add_cfg(REG_DELTA_SCALE, 16'hFFFF);
    add_cfg(REG_PING_PONG, 1);
    add_cfg(REG_LOOPING, 0);
    add_cfg(REG_PLAY_BACKWARD, 1);
    add_checked(OP_STOP, 0, 0, MAX_FRAMES - 1, 1'b1, 1'b0, 1'b0);
    add_item(OP_PLAY, 0, 0, 1'b0);
    add_item(OP_TICK, 16'hFFFF, 0, 1'b0);
    add_item(OP_TICK, 16'hFFFF, 0, 1'b0);
    add_cfg(REG_FRAME_COUNT, 16);
    add_cfg(REG_FRAME_DURATION, 100);
    add_cfg(REG_DELTA_SCALE, 256);
    add_cfg(REG_PING_PONG, 0);
    add_cfg(REG_LOOPING, 1);
    add_cfg(REG_PLAY_BACKWARD, 0);
    add_item(OP_PLAY, 0, 0, 1'b0);
    add_item(OP_TICK, 0, 0, 1'b0);
    add_item(OP_TICK, 100, 0, 1'b0);
    add_item(OP_SET, 0, 15, 1'b0);
    add_cfg(REG_FRAME_COUNT, 4);
    add_cfg(REG_PLAY_BACKWARD, 1);
    add_item(OP_PLAY, 0, 0, 1'b0);
    add_item(OP_TICK, 200, 0, 1'b0);
    add_item(OP_TICK, 200, 0, 1'b0);
    add_cfg(REG_DELTA_SCALE, 0);
    add_item(OP_TICK, 16'hFFFF, 0, 1'b0);
    add_item(OP_SET, 0, -1, 1'b0);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    prev_cfg = 1'b0;
    foreach (plan_q[i]) begin
      if (plan_q[i].is_cfg) begin
        if (!prev_cfg) wait_drain();
        write_reg(plan_q[i].reg_idx, plan_q[i].wdata);
      end else begin
        send_item(plan_q[i].op, plan_q[i].delta, plan_q[i].fidx, plan_q[i].frz,
                  plan_q[i].typed, plan_q[i].res);
      end
      prev_cfg = plan_q[i].is_cfg;
    end

    for (phase = 0; phase < 8; phase++) begin
      sat = (phase == 4);
      n_items = sat ? 320 : 20;
      wait_drain();
      random_setup(sat);
      tx_calm = (phase == 1) || ($urandom_range(0, 3) == 0);
      rx_calm = (phase != 1) && ($urandom_range(0, 3) == 0);
      if (phase == 1) rx_hold = HOLD_CYCLES;
      send_item(OP_PLAY, 16'($urandom), 13'($urandom), 1'($urandom), 1'b0, '0);
      for (k = 0; k < n_items; k++) begin
        if ($urandom_range(0, 49) == 0) wait_drain();
        random_item(sat, op, delta, fidx, frz);
        send_item(op, delta, fidx, frz, 1'b0, '0);
      end
    end

    in_tvalid = 1'b0;
    cfg_we = 1'b0;
    while (frame_status_q.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    if (error_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
